// File: src/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // Payload and datapath widths
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 6;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int LEDS_W     = 11;
    localparam int PLEN_W     = 7;
    localparam int OFS_W      = 12;
    localparam int SW         = 14;   // signed working width for offsets and slots
    localparam int QUO_W      = 19;   // dividend / quotient width
    localparam int DIV_W      = 11;   // divisor / remainder width
    localparam int CNT_W      = 5;    // divider step counter

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RENDER = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_ONCE    = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_STRETCH = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRAW_MODE      = 3'd0,
        REG_PING_PONG      = 3'd1,
        REG_START_DIR      = 3'd2,
        REG_LED_COUNT      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_INDEX,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // write table slot, clear offset
        logic tick;       // step the offset
        logic capture;    // latch pixel index of a render beat
        logic prep;       // latch black flag, set up division
        logic div_start;  // launch the divider
        logic index;      // form slot, issue table read
        logic emit;       // load the output color register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/lps_div.sv
`default_nettype none

module lps_div
    import lps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [QUO_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quotient,
    output logic [DIV_W-1:0]      o_remainder
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   shifted;
    logic             ge;
    logic [DIV_W:0]   diff;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[QUO_W-1]};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    assign o_done      = r_busy && (r_cnt == CNT_W'(1));
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: src/lps_dp.sv
`default_nettype none

module lps_dp
    import lps_pkg::*;
#(
    parameter int MAX_LEDS    = 1024,
    parameter int MAX_PATTERN = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [SLOT_W-1:0]     i_entry_index,
    input  wire logic [COLOR_W-1:0]    i_entry_color,
    input  wire logic [PIX_W-1:0]      i_pixel_index,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic [COLOR_W-1:0]         o_pixel_color
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [12:0] LED_CAP = 13'(MAX_LEDS);
    localparam logic [8:0]  PAT_CAP = 9'(MAX_PATTERN);

    // Configuration and scroll state
    t_mode              r_draw_mode;
    logic               r_ping_pong;
    logic [LEDS_W-1:0]  r_led_count;
    logic [PLEN_W-1:0]  r_pat_len;
    logic [OFS_W-1:0]   r_offset;
    logic               r_dir;

    // Render payload
    logic [PIX_W-1:0]   r_pix;
    logic               r_black;
    logic               r_hit;
    logic [COLOR_W-1:0] r_rdata;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] r_mem [MAX_PATTERN];

    logic [LEDS_W-1:0]   leds;
    logic [PLEN_W-1:0]   pat;
    logic signed [SW-1:0] t14, pix14, l14, p14;
    logic signed [SW-1:0] x, x_adj;
    logic                out_of_strip;
    logic                black;
    logic                need_div;
    logic [QUO_W-1:0]    product;
    logic [QUO_W-1:0]    dividend;
    logic [DIV_W-1:0]    divisor;
    logic                div_done;
    logic [QUO_W-1:0]    quotient;
    logic [DIV_W-1:0]    remainder;
    logic signed [SW-1:0] k_rep0, k_rep;
    logic                hit;
    logic [AW-1:0]       rd_addr;
    logic [8:0]          wr_slot;
    logic                wr_ok;
    logic signed [SW-1:0] tt, hi, lo;
    logic                nd;
    logic                tick_upd;

    // Saturate sizes into their legal ranges
    always_comb begin
        if (r_led_count == '0) begin
            leds = LEDS_W'(1);
        end else if ({2'b0, r_led_count} > LED_CAP) begin
            leds = LED_CAP[LEDS_W-1:0];
        end else begin
            leds = r_led_count;
        end
        if (r_pat_len == '0) begin
            pat = PLEN_W'(1);
        end else if ({2'b0, r_pat_len} > PAT_CAP) begin
            pat = PAT_CAP[PLEN_W-1:0];
        end else begin
            pat = r_pat_len;
        end
    end

    assign t14   = {{(SW-OFS_W){r_offset[OFS_W-1]}}, r_offset};
    assign pix14 = $signed({{(SW-PIX_W){1'b0}}, r_pix});
    assign l14   = $signed({{(SW-LEDS_W){1'b0}}, leds});
    assign p14   = $signed({{(SW-PLEN_W){1'b0}}, pat});

    // Set up the division for repeat (modulo) and stretch (scale)
    always_comb begin
        x            = pix14 - t14;
        x_adj        = (x < 0) ? x + l14 : x;
        out_of_strip = {1'b0, r_pix} >= leds;
        product      = QUO_W'(x_adj[OFS_W-1:0]) * QUO_W'(pat);
        unique case (r_draw_mode)
            MODE_ONCE: begin
                black    = out_of_strip;
                need_div = 1'b0;
            end
            MODE_REPEAT: begin
                black    = out_of_strip;
                need_div = !out_of_strip;
            end
            MODE_STRETCH: begin
                black    = out_of_strip || (x_adj < 0);
                need_div = !(out_of_strip || (x_adj < 0));
            end
            default: begin
                black    = 1'b1;
                need_div = 1'b0;
            end
        endcase
        if (r_draw_mode == MODE_STRETCH) begin
            dividend = product;
            divisor  = leds;
        end else begin
            dividend = QUO_W'(r_pix);
            divisor  = DIV_W'(pat);
        end
    end

    lps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (dividend),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    // Pick the table slot for the pixel
    always_comb begin
        k_rep0 = $signed({{(SW-DIV_W){1'b0}}, remainder}) - t14;
        k_rep  = (k_rep0 < 0) ? k_rep0 + p14 : k_rep0;
        unique case (r_draw_mode)
            MODE_ONCE: begin
                hit     = (x >= 0) && (x < p14);
                rd_addr = x[AW-1:0];
            end
            MODE_REPEAT: begin
                hit     = (k_rep >= 0) && (k_rep < p14);
                rd_addr = k_rep[AW-1:0];
            end
            MODE_STRETCH: begin
                hit     = quotient < QUO_W'(pat);
                rd_addr = quotient[AW-1:0];
            end
            default: begin
                hit     = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    assign wr_slot = {3'b0, i_entry_index};
    assign wr_ok   = wr_slot < PAT_CAP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[wr_slot[AW-1:0]] <= i_entry_color;
        end
        if (i_cmd.index) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Offset step with bound handling
    always_comb begin
        tt       = t14 + (r_dir ? 14'sd1 : -14'sd1);
        nd       = r_dir;
        tick_upd = 1'b1;
        unique case (r_draw_mode)
            MODE_ONCE: begin
                hi = l14 - p14;
                lo = l14 - p14 - 14'sd1;
            end
            MODE_REPEAT: begin
                hi = p14;
                lo = p14 - 14'sd1;
            end
            MODE_STRETCH: begin
                hi = l14 - 14'sd1;
                lo = l14 - 14'sd1;
            end
            default: begin
                hi       = '0;
                lo       = '0;
                tick_upd = 1'b0;
            end
        endcase
        if (tt >= hi) begin
            if (r_ping_pong) begin
                nd = !nd;
            end else begin
                tt = '0;
            end
        end
        if (tt < 0) begin
            if (r_ping_pong) begin
                tt = 14'sd1;
                nd = !nd;
            end else begin
                tt = lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode <= MODE_ONCE;
            r_ping_pong <= 1'b1;
            r_led_count <= LEDS_W'(60);
            r_pat_len   <= PLEN_W'(1);
            r_offset    <= '0;
            r_dir       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_DRAW_MODE: begin
                        r_draw_mode <= t_mode'(i_cfg_data[1:0]);
                        r_offset    <= '0;
                    end
                    REG_PING_PONG:      r_ping_pong <= i_cfg_data[0];
                    REG_START_DIR:      r_dir       <= i_cfg_data[0];
                    REG_LED_COUNT:      r_led_count <= i_cfg_data;
                    REG_PATTERN_LENGTH: r_pat_len   <= i_cfg_data[PLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_offset <= '0;
            end
            if (i_cmd.tick && tick_upd) begin
                r_offset <= tt[OFS_W-1:0];
                r_dir    <= nd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix <= i_pixel_index;
        end
        if (i_cmd.prep) begin
            r_black <= black;
        end
        if (i_cmd.index) begin
            r_hit <= hit && !r_black;
        end
        if (i_cmd.emit) begin
            r_color <= r_hit ? r_rdata : '0;
        end
    end

    assign o_sts.need_div = need_div;
    assign o_sts.div_done = div_done;
    assign o_pixel_color  = r_color;

endmodule

`default_nettype wire

// File: src/lps_ctrl.sv
`default_nettype none

module lps_ctrl
    import lps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic             i_out_stall,
    input  wire t_dp_sts          i_sts,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_dp_cmd               o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD:   o_cmd.load = 1'b1;
                        CMD_TICK:   o_cmd.tick = 1'b1;
                        CMD_RENDER: begin
                            o_cmd.capture = 1'b1;
                            n_state       = ST_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_INDEX;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_INDEX;
                end
            end
            ST_INDEX: begin
                o_cmd.index = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/led_pattern_scroller.sv
// Render path: prep, slot lookup and output load; repeat and stretch mode also wait
//   on the shared bit-serial divider, which once mode and black pixels skip.
// Throughput: load and tick beats 1 per cycle; a render beat stalls the input
//   until its color is loaded into the output register, which waits out output stalls.
// Reset: synchronous active-low; resets control state, offset, direction and config registers;
//   the pattern table keeps no reset value and needs no clearing pass.
`default_nettype none

module led_pattern_scroller
    import lps_pkg::*;
#(
    parameter int MAX_LEDS    = 1024,
    parameter int MAX_PATTERN = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [SLOT_W-1:0]     i_entry_index,
    input  wire logic [COLOR_W-1:0]    i_entry_color,
    input  wire logic [PIX_W-1:0]      i_pixel_index,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COLOR_W-1:0]         o_pixel_color
);

    // The controller sequences one render beat through prep, divide (when needed),
    // slot lookup and output load. Load and tick beats finish in the accept cycle.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // Datapath: config registers, offset/direction, pattern table,
    // shared divider for both modulo (repeat) and scaling (stretch).
    lps_dp #(
        .MAX_LEDS    (MAX_LEDS),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .i_pixel_index (i_pixel_index),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_pixel_color (o_pixel_color)
    );

`ifndef ASSERT_OFF
    // Load the output register only when it is empty or draining
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("color loaded over a held beat");

    // A render beat blocks the input on the next cycle
    a_render_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_RENDER) |=> o_in_stall)
        else $error("render beat did not block input");

    // Load and tick beats leave the input open
    a_short_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command != CMD_RENDER) |=> !o_in_stall)
        else $error("load or tick beat blocked input");

    // Divider never finishes in the cycle after launch
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.div_start |=> !dp_sts.div_done)
        else $error("divider finished too early");
`endif

endmodule

`default_nettype wire
